FILE: src/csm_pkg.sv
// csm_pkg: shared types, mode codes and calendar helpers for the clock-setting menu
// used by csm_if.sv and clock_setting_menu_controller.sv
`default_nettype none
package csm_pkg;

  typedef enum logic [2:0] {
    MODE_MAIN    = 3'd0,
    MODE_YEAR    = 3'd1,
    MODE_MONTH   = 3'd2,
    MODE_WEEKDAY = 3'd3,
    MODE_DATE    = 3'd4,
    MODE_HOUR    = 3'd5,
    MODE_MINUTE  = 3'd6,
    MODE_DAY     = 3'd7
  } mode_t;

  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [3:0] MONTH_MIN   = 4'd1;
  localparam logic [3:0] MONTH_MAX   = 4'd12;
  localparam logic [2:0] WEEKDAY_MIN = 3'd1;
  localparam logic [2:0] WEEKDAY_MAX = 3'd7;
  localparam logic [4:0] DATE_MIN    = 5'd1;
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [5:0] MINUTE_MAX  = 6'd59;

  typedef struct packed {
    logic       press_next;
    logic       press_up;
    logic       press_down;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [2:0] now_weekday;
    logic [4:0] now_date;
    logic [3:0] now_month;
    logic [6:0] now_year;
  } in_item_t;

  typedef struct packed {
    logic [2:0] menu_mode;
    logic [5:0] set_minute;
    logic [4:0] set_hour;
    logic [2:0] set_weekday;
    logic [4:0] set_date;
    logic [3:0] set_month;
    logic [6:0] set_year;
    logic       clock_write;
    logic       backlight_on;
  } out_item_t;

  function automatic logic [4:0] month_limit(input logic [3:0] mon, input logic [6:0] yr);
    logic [4:0] lim;
    unique case (mon)
      4'd4, 4'd6, 4'd9, 4'd11: lim = 5'd30;
      4'd2:                    lim = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default:                 lim = 5'd31;
    endcase
    return lim;
  endfunction

endpackage
`default_nettype wire

FILE: src/csm_if.sv
// csm_in_if / csm_out_if: valid-ready channels for menu ticks and results
// depends on csm_pkg for the payload structs
`default_nettype none
interface csm_in_if import csm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface csm_out_if import csm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/clock_setting_menu_controller.sv
// clock_setting_menu_controller: button-driven menu for setting time and date
// depends on csm_pkg and the channel interfaces in csm_if.sv
//
// Usage: one transfer on in_ch per poll tick carries the three button levels
// and the clock's current time and date. One transfer on out_ch follows for
// each tick, with the menu mode, the stepped fields, the clock write strobe
// and the backlight level.
// Pipeline: a tick is registered in the input register on acceptance, and its
// result is registered in the result register and offered on out_ch as it advances.
// Throughput: one tick per cycle while out_ch.ready stays high; the input
// register and the result register form a two-stage pipeline and the menu
// state updates as a tick moves into the result register.
// Stall: while out_ch.ready is low the result holds, one more tick waits in
// the input register, and in_ch.ready drops only when both are full.
// Reset (rst_n low, synchronous): menu in main view, all arm flags clear,
// backlight off, both pipeline registers empty.
`default_nettype none
module clock_setting_menu_controller
  import csm_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  csm_in_if.sink       in_ch,
  csm_out_if.source    out_ch
);

  logic      s1_v_r;
  in_item_t  s1_r;
  logic      out_v_r;
  out_item_t out_r;

  mode_t     mode_r, mode_nxt;
  logic      next_armed_r, next_armed_nxt;
  logic      up_armed_r, up_armed_nxt;
  logic      down_armed_r, down_armed_nxt;
  logic      backlight_r, backlight_nxt;

  logic      advance;
  out_item_t res;
  mode_t     mode_a;
  logic [5:0] mi;
  logic [4:0] hr;
  logic [2:0] wd;
  logic [4:0] dt;
  logic [3:0] mo;
  logic [6:0] yr;
  logic       wr;
  logic [4:0] dlim;

  assign advance     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || advance;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;
  assign dlim = month_limit(s1_r.now_month, s1_r.now_year);

  always_comb begin
    mode_a         = mode_r;
    next_armed_nxt = next_armed_r;
    up_armed_nxt   = up_armed_r;
    down_armed_nxt = down_armed_r;
    backlight_nxt  = backlight_r;
    mi = s1_r.now_minute;
    hr = s1_r.now_hour;
    wd = s1_r.now_weekday;
    dt = s1_r.now_date;
    mo = s1_r.now_month;
    yr = s1_r.now_year;
    wr = 1'b0;

    if (s1_r.press_next) begin
      if (next_armed_r) begin
        mode_a = (mode_r < MODE_MINUTE) ? mode_t'(mode_r + 3'd1) : MODE_MAIN;
      end
      next_armed_nxt = !next_armed_r;
    end

    if (s1_r.press_up) begin
      if (up_armed_r) begin
        unique case (mode_a)
          MODE_MAIN:    mode_a = MODE_DAY;
          MODE_YEAR:    begin yr = (yr < YEAR_MAX) ? yr + 7'd1 : 7'd0; wr = 1'b1; end
          MODE_MONTH:   begin mo = (mo < MONTH_MAX) ? mo + 4'd1 : MONTH_MIN; wr = 1'b1; end
          MODE_WEEKDAY: begin wd = (wd < WEEKDAY_MAX) ? wd + 3'd1 : WEEKDAY_MIN; wr = 1'b1; end
          MODE_DATE:    begin dt = (dt < dlim) ? dt + 5'd1 : DATE_MIN; wr = 1'b1; end
          MODE_HOUR:    begin hr = (hr < HOUR_MAX) ? hr + 5'd1 : 5'd0; wr = 1'b1; end
          MODE_MINUTE:  begin mi = (mi < MINUTE_MAX) ? mi + 6'd1 : 6'd0; wr = 1'b1; end
          MODE_DAY:     mode_a = MODE_MAIN;
          default:      mode_a = MODE_MAIN;
        endcase
      end
      up_armed_nxt = !up_armed_r;
    end

    if (s1_r.press_down) begin
      if (down_armed_r) begin
        unique case (mode_a)
          MODE_YEAR:    begin yr = (yr > 7'd0) ? yr - 7'd1 : YEAR_MAX; wr = 1'b1; end
          MODE_MONTH:   begin mo = (mo > MONTH_MIN) ? mo - 4'd1 : MONTH_MAX; wr = 1'b1; end
          MODE_WEEKDAY: begin wd = (wd > WEEKDAY_MIN) ? wd - 3'd1 : WEEKDAY_MAX; wr = 1'b1; end
          MODE_DATE:    begin dt = (dt > DATE_MIN) ? dt - 5'd1 : dlim; wr = 1'b1; end
          MODE_HOUR:    begin hr = (hr > 5'd0) ? hr - 5'd1 : HOUR_MAX; wr = 1'b1; end
          MODE_MINUTE:  begin mi = (mi > 6'd0) ? mi - 6'd1 : MINUTE_MAX; wr = 1'b1; end
          MODE_MAIN, MODE_DAY: backlight_nxt = !backlight_r;
          default:      backlight_nxt = !backlight_r;
        endcase
      end
      down_armed_nxt = !down_armed_r;
    end

    mode_nxt         = mode_a;
    res.menu_mode    = mode_a;
    res.set_minute   = mi;
    res.set_hour     = hr;
    res.set_weekday  = wd;
    res.set_date     = dt;
    res.set_month    = mo;
    res.set_year     = yr;
    res.clock_write  = wr;
    res.backlight_on = backlight_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      mode_r       <= MODE_MAIN;
      next_armed_r <= 1'b0;
      up_armed_r   <= 1'b0;
      down_armed_r <= 1'b0;
      backlight_r  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r      <= 1'b1;
        mode_r       <= mode_nxt;
        next_armed_r <= next_armed_nxt;
        up_armed_r   <= up_armed_nxt;
        down_armed_r <= down_armed_nxt;
        backlight_r  <= backlight_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_r <= in_ch.data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

endmodule
`default_nettype wire
